// ===== hw/rtl/telemetry_frame_checker_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Telemetry frame checker assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_CHECKER_UNIT_MACROS_SVH
`define TELEMETRY_FRAME_CHECKER_UNIT_MACROS_SVH

// same-cycle implication
`define TFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tfc_pkg.sv =====
// ---------------------------------------------------------------------------
// Telemetry frame checker package
// Types, codes and constants shared by the checker modules.
// ---------------------------------------------------------------------------
package tfc_pkg;

  localparam int CountLimitDefault = 255;
  localparam int StoreDepth        = 10;
  localparam int QueueDepth        = 2;
  localparam int CfgIdxW           = 2;

  localparam logic [7:0] StartByteReset     = 8'd83;
  localparam logic [7:0] MinLengthReset     = 8'd12;
  localparam logic [7:0] PressureScaleReset = 8'd100;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusShort    = 2'd1,
    StatusBadStart = 2'd2,
    StatusBadSum   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartByte     = 2'd0,
    CfgMinLength     = 2'd1,
    CfgPressureScale = 2'd2
  } cfg_idx_e;

  // frame byte positions 1..10 held at store slots 0..9
  localparam int SlotFlag     = 0;
  localparam int SlotServo    = 1;
  localparam int SlotPressLo  = 2;
  localparam int SlotPressHi  = 3;
  localparam int SlotTemp     = 4;
  localparam int SlotPitch    = 5;
  localparam int SlotRoll     = 6;
  localparam int SlotYaw      = 7;
  localparam int SlotSpeed    = 8;
  localparam int SlotBattery  = 9;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] min_length;
    logic [7:0] pressure_scale;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        flag_byte;
    logic [7:0]        servo_angle;
    logic [23:0]       pressure_pa;
    logic signed [7:0] temperature;
    logic signed [7:0] pitch;
    logic signed [7:0] roll;
    logic signed [7:0] yaw;
    logic signed [7:0] speed;
    logic [7:0]        battery;
  } out_item_t;

  typedef struct packed {
    status_e                         status;
    logic [StoreDepth-1:0][7:0]      fields;
  } frame_rec_t;

endpackage

// ===== hw/rtl/telemetry_frame_checker_unit.sv =====
// ---------------------------------------------------------------------------
// Telemetry frame checker
// Checks and decodes byte-serial telemetry frames.
// ---------------------------------------------------------------------------
// Input channel: one frame byte per request (data_byte, frame_last), taken
// when in_valid_i is high and in_stall_o low; one byte per cycle while unstalled.
// Output channel: one result per frame, on the request that carries
// frame_last: status plus decoded fields, zeroed when status is not ok.
// Path: the edge that takes the last byte writes its record into the record
// queue; the pressure multiply is then registered into the output register,
// which drives out_valid_o. One result per cycle sustained while unstalled.
// Between front and back sits a two-entry record queue; while out_stall_i
// holds, the output register keeps its result, the queue fills, and once it
// is full in_stall_o rises. Non-last bytes still flow until then.
// Config port: sync byte, min_length, pressure_scale at indexes 0..2,
// always ready; other indexes are ignored. Write only while idle.
// Reset: byte count and running sum clear, queue and output empty, config
// returns to sync byte 'S', minimum length 12, pressure scale 100.
// ---------------------------------------------------------------------------
module telemetry_frame_checker_unit #(
  parameter int CountLimit = tfc_pkg::CountLimitDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tfc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tfc_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import tfc_pkg::*;

  cfg_t       cfg_q;
  logic       accept;
  logic       push, pop, full, empty;
  frame_rec_t push_rec, pop_rec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte      <= StartByteReset;
      cfg_q.min_length     <= MinLengthReset;
      cfg_q.pressure_scale <= PressureScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgStartByte:     cfg_q.sync_byte      <= cfg_data_i;
        CfgMinLength:     cfg_q.min_length     <= cfg_data_i;
        CfgPressureScale: cfg_q.pressure_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tfc_front #(
    .CountLimit(CountLimit)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_rec)
  );

  tfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_rec),
    .empty_o    (empty)
  );

  tfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .rec_avail_i(!empty),
    .rec_i      (pop_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/tfc_queue.sv =====
// ---------------------------------------------------------------------------
// Telemetry frame checker record queue
// Short FIFO of checked frame records between the front and back parts.
// ---------------------------------------------------------------------------
`include "telemetry_frame_checker_unit_macros.svh"

module tfc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tfc_pkg::frame_rec_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output tfc_pkg::frame_rec_t pop_data_o,
  output logic               empty_o
);
  import tfc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  frame_rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TFC_ASSERT_NOW(a_q_no_overflow, push_i, !full_o, "queue push while full")
  `TFC_ASSERT_NOW(a_q_no_underflow, pop_i, !empty_o, "queue pop while empty")
  `TFC_ASSERT_NEXT(a_q_drain, pop_i && !push_i, cnt_q == $past(cnt_q) - 1'b1, "queue count off")
  `TFC_ASSERT_NEXT(a_q_fill, push_i && !pop_i, !empty_o, "queue lost a record")

endmodule

// ===== hw/rtl/tfc_front.sv =====
// ---------------------------------------------------------------------------
// Telemetry frame checker front
// Counts and sums frame bytes, keeps the header fields, grades the frame.
// ---------------------------------------------------------------------------
module tfc_front #(
  parameter int CountLimit = tfc_pkg::CountLimitDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfc_pkg::cfg_t       cfg_i,
  input  logic                accept_i,
  input  tfc_pkg::in_item_t   in_data_i,
  output logic                push_o,
  output tfc_pkg::frame_rec_t push_data_o
);
  import tfc_pkg::*;

  localparam int CntW = $clog2(CountLimit + 1);
  localparam int CmpW = (CntW > 8) ? CntW : 8;

  logic [CntW-1:0]            cnt_q, cnt_d, cnt_inc;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 first_q, first_d;
  logic [StoreDepth-1:0][7:0] store_q, store_d;
  logic [7:0]                 b;
  logic                       at_start;
  status_e                    status;

  assign b        = in_data_i.data_byte;
  assign at_start = (cnt_q == '0);
  assign cnt_inc  = (cnt_q < CntW'(CountLimit)) ? cnt_q + 1'b1 : cnt_q;
  assign first_d  = at_start ? b : first_q;

  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (at_start) begin
        store_d[i] = '0;
      end else if (cnt_q == CntW'(i + 1)) begin
        store_d[i] = b;
      end else begin
        store_d[i] = store_q[i];
      end
    end
  end

  always_comb begin
    priority if (CmpW'(cnt_inc) < CmpW'(cfg_i.min_length)) begin
      status = StatusShort;
    end else if (first_d != cfg_i.sync_byte) begin
      status = StatusBadStart;
    end else if (sum_q != b) begin
      status = StatusBadSum;
    end else begin
      status = StatusOk;
    end
  end

  assign cnt_d = in_data_i.frame_last ? '0 : cnt_inc;
  assign sum_d = in_data_i.frame_last ? '0 : sum_q + b;

  assign push_o             = accept_i && in_data_i.frame_last;
  assign push_data_o.status = status;
  assign push_data_o.fields = store_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      first_q <= first_d;
      store_q <= store_d;
    end
  end

endmodule

// ===== hw/rtl/tfc_back.sv =====
// ---------------------------------------------------------------------------
// Telemetry frame checker back
// Scales pressure and presents one result per frame in an output register.
// ---------------------------------------------------------------------------
module tfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfc_pkg::cfg_t       cfg_i,
  input  logic                rec_avail_i,
  input  tfc_pkg::frame_rec_t rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tfc_pkg::out_item_t  out_data_o
);
  import tfc_pkg::*;

  logic       valid_q;
  out_item_t  out_q, out_d;
  logic [15:0] raw;

  assign pop_o = rec_avail_i && (!valid_q || !out_stall_i);
  assign raw   = {rec_i.fields[SlotPressHi], rec_i.fields[SlotPressLo]};

  always_comb begin
    out_d        = '0;
    out_d.status = rec_i.status;
    if (rec_i.status == StatusOk) begin
      out_d.flag_byte   = rec_i.fields[SlotFlag];
      out_d.servo_angle = rec_i.fields[SlotServo];
      out_d.pressure_pa = 24'(raw) * 24'(cfg_i.pressure_scale);
      out_d.temperature = rec_i.fields[SlotTemp];
      out_d.pitch       = rec_i.fields[SlotPitch];
      out_d.roll        = rec_i.fields[SlotRoll];
      out_d.yaw         = rec_i.fields[SlotYaw];
      out_d.speed       = rec_i.fields[SlotSpeed];
      out_d.battery     = rec_i.fields[SlotBattery];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule
